// ===== hdl/rc4_pkg.sv =====
// ----------------------------------------------------------------------------
// RC4 cipher core package
// Shared types, control word layout and the microcode program of the core.
// ----------------------------------------------------------------------------
package rc4_pkg;

   localparam int unsigned KEY_BYTES_DEF = 256;
   localparam int unsigned SBOX_DEPTH    = 256;

   typedef enum logic [1:0] {
      CMD_KEY   = 2'd0,
      CMD_SCHED = 2'd1,
      CMD_DATA  = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [0:0] {
      CSR_KEY_LENGTH    = 1'b0,
      CSR_DISCARD_COUNT = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      SEQ_NEXT,
      SEQ_GOTO,
      SEQ_BRANCH,
      SEQ_DISPATCH
   } seq_op_type;

   typedef enum logic [1:0] {
      COND_N_MORE,
      COND_DISC_ZERO,
      COND_OUT_BUSY
   } cond_type;

   typedef enum logic [1:0] { I_HOLD, I_INC, I_CLR } i_op_type;
   typedef enum logic [1:0] { J_HOLD, J_CLR, J_ADD, J_ADD_KEY } j_op_type;
   typedef enum logic [1:0] { N_HOLD, N_CLR, N_INC } n_op_type;
   typedef enum logic [1:0] { K_HOLD, K_CLR, K_STEP } k_op_type;
   typedef enum logic [1:0] { D_HOLD, D_LOAD, D_DEC } d_op_type;

   typedef enum logic [2:0] {
      RA_N,
      RA_I_NEXT,
      RA_J_SUM,
      RA_SI_RD,
      RA_T
   } ra_sel_type;

   typedef enum logic [2:0] {
      WR_NONE,
      WR_N_IDX,
      WR_N_RD,
      WR_I_RD,
      WR_J_SI
   } wr_sel_type;

   typedef logic [4:0] upc_type;

   localparam upc_type STEP_IDLE    = 5'd0;
   localparam upc_type STEP_KS_INIT = 5'd1;
   localparam upc_type STEP_FILL    = 5'd2;
   localparam upc_type STEP_K0      = 5'd3;
   localparam upc_type STEP_K1      = 5'd4;
   localparam upc_type STEP_K2      = 5'd5;
   localparam upc_type STEP_K3      = 5'd6;
   localparam upc_type STEP_KS_DONE = 5'd7;
   localparam upc_type STEP_D_CHK   = 5'd8;
   localparam upc_type STEP_D0      = 5'd9;
   localparam upc_type STEP_D1      = 5'd10;
   localparam upc_type STEP_D2      = 5'd11;
   localparam upc_type STEP_D3      = 5'd12;
   localparam upc_type STEP_C0      = 5'd13;
   localparam upc_type STEP_C1      = 5'd14;
   localparam upc_type STEP_C2      = 5'd15;
   localparam upc_type STEP_C3      = 5'd16;

   typedef struct packed {
      seq_op_type seq_op;
      cond_type   cond;
      upc_type    target;
      logic       accept;
      logic       emit;
      logic       si_ld;
      logic       sj_ld;
      i_op_type   i_op;
      j_op_type   j_op;
      n_op_type   n_op;
      k_op_type   k_op;
      d_op_type   d_op;
      ra_sel_type ra_sel;
      wr_sel_type wr_sel;
   } ctrl_word_type;

   typedef struct packed {
      logic n_more;
      logic disc_zero;
      logic out_busy;
   } dp_status_type;

   localparam ctrl_word_type CTRL_NOP = '{
      seq_op: SEQ_NEXT,
      cond:   COND_N_MORE,
      target: STEP_IDLE,
      accept: 1'b0,
      emit:   1'b0,
      si_ld:  1'b0,
      sj_ld:  1'b0,
      i_op:   I_HOLD,
      j_op:   J_HOLD,
      n_op:   N_HOLD,
      k_op:   K_HOLD,
      d_op:   D_HOLD,
      ra_sel: RA_T,
      wr_sel: WR_NONE
   };

   // One keystream step takes four control words: fetch S[i], fetch S[j],
   // write S[i] while fetching the output entry, write S[j].
   function automatic ctrl_word_type ucode_rom(input upc_type addr);
      ctrl_word_type w;
      w = CTRL_NOP;
      unique case (addr)
         STEP_IDLE: begin
            w.seq_op = SEQ_DISPATCH;
            w.accept = 1'b1;
         end
         STEP_KS_INIT: begin
            w.n_op = N_CLR;
            w.j_op = J_CLR;
            w.k_op = K_CLR;
         end
         STEP_FILL: begin
            w.wr_sel = WR_N_IDX;
            w.n_op   = N_INC;
            w.seq_op = SEQ_BRANCH;
            w.cond   = COND_N_MORE;
            w.target = STEP_FILL;
         end
         STEP_K0: begin
            w.ra_sel = RA_N;
         end
         STEP_K1: begin
            w.si_ld  = 1'b1;
            w.j_op   = J_ADD_KEY;
            w.ra_sel = RA_J_SUM;
         end
         STEP_K2: begin
            w.sj_ld  = 1'b1;
            w.wr_sel = WR_N_RD;
         end
         STEP_K3: begin
            w.wr_sel = WR_J_SI;
            w.n_op   = N_INC;
            w.k_op   = K_STEP;
            w.seq_op = SEQ_BRANCH;
            w.cond   = COND_N_MORE;
            w.target = STEP_K0;
         end
         STEP_KS_DONE: begin
            w.i_op = I_CLR;
            w.j_op = J_CLR;
            w.d_op = D_LOAD;
         end
         STEP_D_CHK: begin
            w.seq_op = SEQ_BRANCH;
            w.cond   = COND_DISC_ZERO;
            w.target = STEP_IDLE;
         end
         STEP_D0, STEP_C0: begin
            w.i_op   = I_INC;
            w.ra_sel = RA_I_NEXT;
         end
         STEP_D1, STEP_C1: begin
            w.si_ld  = 1'b1;
            w.j_op   = J_ADD;
            w.ra_sel = RA_J_SUM;
         end
         STEP_D2, STEP_C2: begin
            w.sj_ld  = 1'b1;
            w.wr_sel = WR_I_RD;
            w.ra_sel = RA_SI_RD;
         end
         STEP_D3: begin
            w.wr_sel = WR_J_SI;
            w.d_op   = D_DEC;
            w.seq_op = SEQ_GOTO;
            w.target = STEP_D_CHK;
         end
         STEP_C3: begin
            w.wr_sel = WR_J_SI;
            w.ra_sel = RA_T;
            w.emit   = 1'b1;
            w.seq_op = SEQ_BRANCH;
            w.cond   = COND_OUT_BUSY;
            w.target = STEP_C3;
         end
         default: begin
            w.seq_op = SEQ_GOTO;
            w.target = STEP_IDLE;
         end
      endcase
      // The output step is kept a branch, so it repeats while the output is busy.
      if (addr == STEP_C3) begin
         w.seq_op = SEQ_BRANCH;
      end
      return w;
   endfunction

endpackage

// ===== hdl/rc4_seq.sv =====
// ----------------------------------------------------------------------------
// RC4 microcode sequencer
// Step counter over the control store, with command dispatch and branches.
// ----------------------------------------------------------------------------
module rc4_seq import rc4_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic [1:0]    req_command,
   input  dp_status_type stat,
   output ctrl_word_type ctrl
);

   upc_type upc_ff;
   upc_type upc_in;
   logic    cond_hit;
   upc_type fall_through;

   assign ctrl = ucode_rom(upc_ff);

   always_comb begin
      unique case (ctrl.cond)
         COND_N_MORE:    cond_hit = stat.n_more;
         COND_DISC_ZERO: cond_hit = stat.disc_zero;
         COND_OUT_BUSY:  cond_hit = stat.out_busy;
         default:        cond_hit = 1'b0;
      endcase
   end

   // The output step is the last of its routine, so a branch not taken there
   // returns to idle instead of running into the next address.
   always_comb begin
      if (upc_ff == STEP_C3) begin
         fall_through = STEP_IDLE;
      end else begin
         fall_through = upc_ff + 5'd1;
      end
   end

   always_comb begin
      upc_in = upc_ff;
      unique case (ctrl.seq_op)
         SEQ_NEXT:   upc_in = fall_through;
         SEQ_GOTO:   upc_in = ctrl.target;
         SEQ_BRANCH: upc_in = cond_hit ? ctrl.target : fall_through;
         SEQ_DISPATCH: begin
            if (req_valid) begin
               unique case (cmd_type'(req_command))
                  CMD_SCHED: upc_in = STEP_KS_INIT;
                  CMD_DATA:  upc_in = STEP_C0;
                  default:   upc_in = STEP_IDLE;
               endcase
            end else begin
               upc_in = STEP_IDLE;
            end
         end
         default: upc_in = STEP_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= STEP_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

// ===== hdl/rc4_dpath.sv =====
// ----------------------------------------------------------------------------
// RC4 datapath
// S-box and key store memories, index registers and the output register.
// ----------------------------------------------------------------------------
module rc4_dpath import rc4_pkg::*; #(
   parameter int unsigned KEY_BYTES = KEY_BYTES_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  ctrl_word_type ctrl,
   input  logic          req_valid,
   input  logic [1:0]    req_command,
   input  logic [7:0]    req_key_index,
   input  logic [7:0]    req_byte_in,
   output logic          rsp_valid,
   output logic [7:0]    rsp_byte_out,
   input  logic          rsp_ready,
   input  logic [8:0]    key_length,
   input  logic [12:0]   discard_count,
   output dp_status_type stat
);

   localparam int unsigned KAW        = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
   localparam logic [8:0]  KEY_COUNT  = 9'(KEY_BYTES);
   localparam logic [8:0]  KEY_LAST   = 9'(KEY_BYTES - 1);

   logic [7:0] sbox_mem_ff [SBOX_DEPTH];
   logic [7:0] key_mem_ff [KEY_BYTES];
   logic [7:0] rd_ff;
   logic [7:0] kd_ff;

   logic [7:0]     i_ff, i_in;
   logic [7:0]     j_ff, j_in;
   logic [7:0]     n_ff, n_in;
   logic [KAW-1:0] k_ff, k_in;
   logic [12:0]    disc_ff, disc_in;
   logic [7:0]     si_ff, si_in;
   logic [7:0]     sj_ff, sj_in;
   logic [7:0]     data_ff, data_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [7:0]     rsp_byte_ff, rsp_byte_in;

   logic       accept;
   logic       key_we;
   logic [7:0] j_sum;
   logic [7:0] t_sum;
   logic [7:0] ks;
   logic [7:0] raddr;
   logic       wr_en;
   logic [7:0] waddr;
   logic [7:0] wdata;
   logic [8:0] len_last;
   logic       out_busy;
   logic       emit_ok;

   assign accept = ctrl.accept && req_valid;
   assign key_we = accept && (cmd_type'(req_command) == CMD_KEY)
                   && ({1'b0, req_key_index} < KEY_COUNT);

   assign j_sum = j_ff + rd_ff + ((ctrl.j_op == J_ADD_KEY) ? kd_ff : 8'd0);
   assign t_sum = si_ff + sj_ff;

   // The output entry is read in the same cycle that S[i] is written and
   // before S[j] is, so entries touched by the swap take the swapped value.
   always_comb begin
      if (t_sum == j_ff) begin
         ks = si_ff;
      end else if (t_sum == i_ff) begin
         ks = sj_ff;
      end else begin
         ks = rd_ff;
      end
   end

   always_comb begin
      if (key_length == 9'd0) begin
         len_last = 9'd0;
      end else if (key_length > KEY_COUNT) begin
         len_last = KEY_LAST;
      end else begin
         len_last = key_length - 9'd1;
      end
   end

   always_comb begin
      unique case (ctrl.ra_sel)
         RA_N:      raddr = n_ff;
         RA_I_NEXT: raddr = i_ff + 8'd1;
         RA_J_SUM:  raddr = j_sum;
         RA_SI_RD:  raddr = si_ff + rd_ff;
         RA_T:      raddr = t_sum;
         default:   raddr = t_sum;
      endcase
   end

   always_comb begin
      wr_en = 1'b1;
      waddr = n_ff;
      wdata = rd_ff;
      unique case (ctrl.wr_sel)
         WR_N_IDX: begin
            waddr = n_ff;
            wdata = n_ff;
         end
         WR_N_RD: begin
            waddr = n_ff;
            wdata = rd_ff;
         end
         WR_I_RD: begin
            waddr = i_ff;
            wdata = rd_ff;
         end
         WR_J_SI: begin
            waddr = j_ff;
            wdata = si_ff;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   assign out_busy = rsp_valid_ff && !rsp_ready;
   assign emit_ok  = ctrl.emit && !out_busy;

   always_comb begin
      i_in = i_ff;
      case (ctrl.i_op)
         I_INC:   i_in = i_ff + 8'd1;
         I_CLR:   i_in = 8'd0;
         default: i_in = i_ff;
      endcase

      j_in = j_ff;
      case (ctrl.j_op)
         J_CLR:     j_in = 8'd0;
         J_ADD:     j_in = j_sum;
         J_ADD_KEY: j_in = j_sum;
         default:   j_in = j_ff;
      endcase

      n_in = n_ff;
      case (ctrl.n_op)
         N_CLR:   n_in = 8'd0;
         N_INC:   n_in = n_ff + 8'd1;
         default: n_in = n_ff;
      endcase

      k_in = k_ff;
      case (ctrl.k_op)
         K_CLR:   k_in = '0;
         K_STEP:  k_in = (9'(k_ff) == len_last) ? '0 : k_ff + KAW'(1);
         default: k_in = k_ff;
      endcase

      disc_in = disc_ff;
      case (ctrl.d_op)
         D_LOAD:  disc_in = discard_count;
         D_DEC:   disc_in = disc_ff - 13'd1;
         default: disc_in = disc_ff;
      endcase

      si_in   = ctrl.si_ld ? rd_ff : si_ff;
      sj_in   = ctrl.sj_ld ? rd_ff : sj_ff;
      data_in = accept ? req_byte_in : data_ff;

      if (emit_ok) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = data_ff ^ ks;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_ready;
         rsp_byte_in  = rsp_byte_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         i_ff         <= 8'd0;
         j_ff         <= 8'd0;
         n_ff         <= 8'd0;
         k_ff         <= '0;
         disc_ff      <= 13'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         i_ff         <= i_in;
         j_ff         <= j_in;
         n_ff         <= n_in;
         k_ff         <= k_in;
         disc_ff      <= disc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      si_ff       <= si_in;
      sj_ff       <= sj_in;
      data_ff     <= data_in;
      rsp_byte_ff <= rsp_byte_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         sbox_mem_ff[waddr] <= wdata;
      end
      rd_ff <= sbox_mem_ff[raddr];
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem_ff[req_key_index[KAW-1:0]] <= req_byte_in;
      end
      kd_ff <= key_mem_ff[k_ff];
   end

   assign stat.n_more    = (n_ff != 8'd255);
   assign stat.disc_zero = (disc_ff == 13'd0);
   assign stat.out_busy  = out_busy;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_byte_out = rsp_byte_ff;

endmodule

// ===== hdl/rc4_stream_cipher_core.sv =====
// ----------------------------------------------------------------------------
// RC4 stream cipher core
// Microcoded RC4 engine with key store, key schedule, discard and crypt.
// ----------------------------------------------------------------------------
// Usage: items arrive on the req_ channel with a command. A key byte item
// writes req_byte_in into the key store at req_key_index. A schedule item
// fills the S-box, runs the 256-step key schedule over the first key_length
// key bytes, clears i and j and drops discard_count keystream bytes. A data
// item returns req_byte_in XOR the next keystream byte on the rsp_ channel.
// Items are handled one at a time; each keystream byte costs four steps of
// the sequencer because every S-box read, and the two swap writes, go
// through one memory port each. The result sits in an output register, so
// the next item is accepted while it waits. A stalled receiver holds the
// core in its output step only when a new data byte is ready and the
// previous one has still not been taken. Configuration registers are
// written through csr_ while the core is idle; the user keeps to this, as
// the block itself does not enforce it. Reset clears i, j, the sequencer
// and the output valid, and sets key_length to 16 and discard_count to 0;
// key store and S-box must be written first.
// ----------------------------------------------------------------------------
module rc4_stream_cipher_core import rc4_pkg::*; #(
   parameter int unsigned KEY_BYTES = KEY_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [7:0]  req_key_index,
   input  logic [7:0]  req_byte_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_byte_out,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [12:0] csr_wdata
);

   logic [8:0]    key_length_ff, key_length_in;
   logic [12:0]   discard_count_ff, discard_count_in;
   ctrl_word_type ctrl;
   dp_status_type stat;

   always_comb begin
      key_length_in    = key_length_ff;
      discard_count_in = discard_count_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_KEY_LENGTH:    key_length_in    = csr_wdata[8:0];
            CSR_DISCARD_COUNT: discard_count_in = csr_wdata;
            default:           key_length_in    = key_length_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_length_ff    <= 9'd16;
         discard_count_ff <= 13'd0;
      end else begin
         key_length_ff    <= key_length_in;
         discard_count_ff <= discard_count_in;
      end
   end

   assign req_ready = ctrl.accept;

   rc4_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .stat        (stat),
      .ctrl        (ctrl)
   );

   rc4_dpath #(
      .KEY_BYTES (KEY_BYTES)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (ctrl),
      .req_valid     (req_valid),
      .req_command   (req_command),
      .req_key_index (req_key_index),
      .req_byte_in   (req_byte_in),
      .rsp_valid     (rsp_valid),
      .rsp_byte_out  (rsp_byte_out),
      .rsp_ready     (rsp_ready),
      .key_length    (key_length_ff),
      .discard_count (discard_count_ff),
      .stat          (stat)
   );

`ifndef SYNTH
   // A result that can be delivered shows up in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      ctrl.emit && !stat.out_busy |=> rsp_valid)
      else $error("result not registered after output step");

   // A new result only ever comes from the output step.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(ctrl.emit))
      else $error("result appeared without an output step");

   // The sequencer waits in the output step while the receiver stalls.
   assert property (@(posedge clock) disable iff (reset)
      ctrl.emit && stat.out_busy |=> ctrl.emit)
      else $error("sequencer left the output step while stalled");
`endif

endmodule
